// ----- design/fmre_pkg.sv -----
// Package for the fax MH run-length encoder: payload types, code table
// constants and the T.4 codeword ROM. No dependencies.
package fmre_pkg;

  // Widest line the run counter and line position have to cover
  localparam logic [11:0] MAX_LINE_WIDTH = 12'd2560;
  localparam logic [11:0] LINE_WIDTH_RST = 12'd1728;
  localparam logic [11:0] POS_SAT        = 12'hFFF;

  // Table bases in the codeword ROM
  localparam logic [7:0] WHITE_TERM_BASE = 8'd0;
  localparam logic [7:0] BLACK_TERM_BASE = 8'd64;
  localparam logic [7:0] WHITE_MAKE_BASE = 8'd128;
  localparam logic [7:0] BLACK_MAKE_BASE = 8'd168;
  localparam logic [5:0] MAKE_LAST       = 6'd39;

  localparam int unsigned ROM_DEPTH = 208;
  localparam int unsigned MAX_CODES = 8;
  localparam int unsigned NUM_CAND  = 10;

  // EOL codeword and its bare length, RTC tail in four chunks
  localparam logic [18:0] EOL_BITS    = 19'd1;
  localparam logic [4:0]  EOL_LEN     = 5'd12;
  localparam logic [2:0]  EOL_PHASE   = 3'd4;
  localparam logic [4:0]  RTC_LEN     = 5'd15;
  localparam logic [18:0] RTC_CHUNK [4] = '{19'h0008, 19'h0040, 19'h0200, 19'h1001};

  typedef struct packed {
    logic pixel;
    logic end_of_page;
  } in_item_t;

  typedef struct packed {
    logic [18:0] code_bits;
    logic [4:0]  code_length;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [18:0] bits;
    logic [4:0]  len;
  } code_t;

  // ROM word: {length[3:0], code[12:0]}
  localparam logic [16:0] CODE_ROM [ROM_DEPTH] = '{
    // white terminating 0..63
    {4'd8,13'h35},{4'd6,13'h07},{4'd4,13'h7},{4'd4,13'h8},{4'd4,13'hB},{4'd4,13'hC},
    {4'd4,13'hE},{4'd4,13'hF},{4'd5,13'h13},{4'd5,13'h14},{4'd5,13'h07},{4'd5,13'h08},
    {4'd6,13'h08},{4'd6,13'h03},{4'd6,13'h34},{4'd6,13'h35},{4'd6,13'h2A},{4'd6,13'h2B},
    {4'd7,13'h27},{4'd7,13'h0C},{4'd7,13'h08},{4'd7,13'h17},{4'd7,13'h03},{4'd7,13'h04},
    {4'd7,13'h28},{4'd7,13'h2B},{4'd7,13'h13},{4'd7,13'h24},{4'd7,13'h18},{4'd8,13'h02},
    {4'd8,13'h03},{4'd8,13'h1A},{4'd8,13'h1B},{4'd8,13'h12},{4'd8,13'h13},{4'd8,13'h14},
    {4'd8,13'h15},{4'd8,13'h16},{4'd8,13'h17},{4'd8,13'h28},{4'd8,13'h29},{4'd8,13'h2A},
    {4'd8,13'h2B},{4'd8,13'h2C},{4'd8,13'h2D},{4'd8,13'h04},{4'd8,13'h05},{4'd8,13'h0A},
    {4'd8,13'h0B},{4'd8,13'h52},{4'd8,13'h53},{4'd8,13'h54},{4'd8,13'h55},{4'd8,13'h24},
    {4'd8,13'h25},{4'd8,13'h58},{4'd8,13'h59},{4'd8,13'h5A},{4'd8,13'h5B},{4'd8,13'h4A},
    {4'd8,13'h4B},{4'd8,13'h32},{4'd8,13'h33},{4'd8,13'h34},
    // black terminating 0..63
    {4'd10,13'h37},{4'd3,13'h2},{4'd2,13'h3},{4'd2,13'h2},{4'd3,13'h3},{4'd4,13'h3},
    {4'd4,13'h2},{4'd5,13'h3},{4'd6,13'h5},{4'd6,13'h4},{4'd7,13'h4},{4'd7,13'h5},
    {4'd7,13'h7},{4'd8,13'h4},{4'd8,13'h7},{4'd9,13'h18},{4'd10,13'h17},{4'd10,13'h18},
    {4'd10,13'h08},{4'd11,13'h67},{4'd11,13'h68},{4'd11,13'h6C},{4'd11,13'h37},
    {4'd11,13'h28},{4'd11,13'h17},{4'd11,13'h18},{4'd12,13'hCA},{4'd12,13'hCB},
    {4'd12,13'hCC},{4'd12,13'hCD},{4'd12,13'h68},{4'd12,13'h69},{4'd12,13'h6A},
    {4'd12,13'h6B},{4'd12,13'hD2},{4'd12,13'hD3},{4'd12,13'hD4},{4'd12,13'hD5},
    {4'd12,13'hD6},{4'd12,13'hD7},{4'd12,13'h6C},{4'd12,13'h6D},{4'd12,13'hDA},
    {4'd12,13'hDB},{4'd12,13'h54},{4'd12,13'h55},{4'd12,13'h56},{4'd12,13'h57},
    {4'd12,13'h64},{4'd12,13'h65},{4'd12,13'h52},{4'd12,13'h53},{4'd12,13'h24},
    {4'd12,13'h37},{4'd12,13'h38},{4'd12,13'h27},{4'd12,13'h28},{4'd12,13'h58},
    {4'd12,13'h59},{4'd12,13'h2B},{4'd12,13'h2C},{4'd12,13'h5A},{4'd12,13'h66},
    {4'd12,13'h67},
    // white makeup 64..1728, then shared extended 1792..2560
    {4'd5,13'h1B},{4'd5,13'h12},{4'd6,13'h17},{4'd7,13'h37},{4'd8,13'h36},{4'd8,13'h37},
    {4'd8,13'h64},{4'd8,13'h65},{4'd8,13'h68},{4'd8,13'h67},{4'd9,13'hCC},{4'd9,13'hCD},
    {4'd9,13'hD2},{4'd9,13'hD3},{4'd9,13'hD4},{4'd9,13'hD5},{4'd9,13'hD6},{4'd9,13'hD7},
    {4'd9,13'hD8},{4'd9,13'hD9},{4'd9,13'hDA},{4'd9,13'hDB},{4'd9,13'h98},{4'd9,13'h99},
    {4'd9,13'h9A},{4'd6,13'h18},{4'd9,13'h9B},
    {4'd11,13'h08},{4'd11,13'h0C},{4'd11,13'h0D},{4'd12,13'h12},{4'd12,13'h13},
    {4'd12,13'h14},{4'd12,13'h15},{4'd12,13'h16},{4'd12,13'h17},{4'd12,13'h1C},
    {4'd12,13'h1D},{4'd12,13'h1E},{4'd12,13'h1F},
    // black makeup 64..1728, then shared extended 1792..2560
    {4'd10,13'h0F},{4'd12,13'hC8},{4'd12,13'hC9},{4'd12,13'h5B},{4'd12,13'h33},
    {4'd12,13'h34},{4'd12,13'h35},{4'd13,13'h6C},{4'd13,13'h6D},{4'd13,13'h4A},
    {4'd13,13'h4B},{4'd13,13'h4C},{4'd13,13'h4D},{4'd13,13'h72},{4'd13,13'h73},
    {4'd13,13'h74},{4'd13,13'h75},{4'd13,13'h76},{4'd13,13'h77},{4'd13,13'h52},
    {4'd13,13'h53},{4'd13,13'h54},{4'd13,13'h55},{4'd13,13'h5A},{4'd13,13'h5B},
    {4'd13,13'h64},{4'd13,13'h65},
    {4'd11,13'h08},{4'd11,13'h0C},{4'd11,13'h0D},{4'd12,13'h12},{4'd12,13'h13},
    {4'd12,13'h14},{4'd12,13'h15},{4'd12,13'h16},{4'd12,13'h17},{4'd12,13'h1C},
    {4'd12,13'h1D},{4'd12,13'h1E},{4'd12,13'h1F}
  };

  // ROM word expanded to a right-aligned code
  function automatic code_t rom_code(input logic [7:0] idx);
    logic [16:0] w;
    code_t       c;
    w      = CODE_ROM[idx];
    c.bits = {6'd0, w[12:0]};
    c.len  = {1'b0, w[16:13]};
    return c;
  endfunction

endpackage

// ----- design/fax_mh_run_length_encoder.sv -----
// Fax MH run-length encoder top level: run counting, T.4 code lookup and
// the code burst buffer. Depends on fmre_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i): one pixel a
//    transfer, with an end-of-page flag on the final pixel of the page.
//  - Output channel (out_valid_o / out_stall_i / out_data_o): one codeword
//    a transfer, right aligned, with last set on the final code of a pixel.
//  - cfg_we_i / cfg_wdata_i write the line width; write only while idle.
//  - A pixel is registered in the input register, coded in one pass into a
//    buffer of up to eight codes, and the buffer drains one code a cycle,
//    unless the output stalls, into the output register.
//  - Mid-run pixels make no code and stream at one a cycle while the buffer
//    is empty. A pixel that makes more than one code holds the input while
//    the buffer drains.
//  - Reset clears the run state, the byte phase and the page flag, and sets
//    the line width to 1728. The first pixel then gets the page-start EOL.
//  - A stall on the output holds the output register; while codes remain in
//    the buffer, the next pixel waits and the input stalls, losing nothing.
module fax_mh_run_length_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [11:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fmre_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fmre_pkg::out_item_t out_data_o
);
  import fmre_pkg::*;

  // Registers
  logic [11:0] line_width_q;
  logic        in_vld_q;
  in_item_t    in_q;
  logic        run_color_q,  run_color_d;
  logic [11:0] run_count_q,  run_count_d;
  logic [11:0] line_pos_q,   line_pos_d;
  logic [2:0]  bit_phase_q,  bit_phase_d;
  logic        page_start_q, page_start_d;
  code_t       slot_q [MAX_CODES];
  code_t       slot_d [MAX_CODES];
  logic [3:0]  rem_q,        rem_d;
  logic [2:0]  rd_ptr_q;
  logic        out_vld_q;
  out_item_t   out_q;

  // Handshake
  logic in_take;
  logic pop;
  logic buf_free;
  logic load;

  // Coding pass
  logic [11:0] width;
  logic        cur_color;
  logic [11:0] cur_count;
  logic [11:0] cur_pos;
  logic        chg_a, make_a;
  logic        end_line, make_b;
  logic [11:0] cnt_next, cnt_b, pos_b;
  logic [5:0]  m_a, m_b;
  logic [7:0]  idx_ma, idx_ta, idx_mb, idx_tb;
  code_t       c_ma, c_ta, c_mb, c_tb, c_eol;
  logic [2:0]  ph1, ph2, ph3, fill;
  logic [3:0]  o1, o3, n_pre, n_new;
  logic [2:0]  rtc_kept;
  code_t       cand     [NUM_CAND];
  logic        cand_en  [NUM_CAND];
  logic [3:0]  cand_pos [NUM_CAND];

  // Transfer control
  assign pop      = (rem_q != 4'd0) && (!out_vld_q || !out_stall_i);
  assign buf_free = (rem_q == 4'd0) || ((rem_q == 4'd1) && pop);
  assign load     = in_vld_q && buf_free;
  assign in_stall_o = in_vld_q && !load;
  assign in_take  = in_valid_i && !in_stall_o;

  // Width clamp and page-start view of the state
  always_comb begin
    if (line_width_q == 12'd0) begin
      width = 12'd1;
    end else if (line_width_q > MAX_LINE_WIDTH) begin
      width = MAX_LINE_WIDTH;
    end else begin
      width = line_width_q;
    end
    cur_color = page_start_q ? run_color_q : 1'b0;
    cur_count = page_start_q ? run_count_q : 12'd0;
    cur_pos   = page_start_q ? line_pos_q  : 12'd0;
  end

  // Run bookkeeping for this pixel
  always_comb begin
    chg_a    = in_q.pixel != cur_color;
    make_a   = chg_a && (cur_count[11:6] != 6'd0);
    cnt_next = chg_a ? 12'd0 : cur_count;
    cnt_b    = (cnt_next < MAX_LINE_WIDTH) ? cnt_next + 12'd1 : cnt_next;
    pos_b    = (cur_pos < POS_SAT) ? cur_pos + 12'd1 : cur_pos;
    end_line = (pos_b >= width) || in_q.end_of_page;
    make_b   = end_line && (cnt_b[11:6] != 6'd0);

    m_a = cur_count[11:6] - 6'd1;
    if (m_a > MAKE_LAST) m_a = MAKE_LAST;
    m_b = cnt_b[11:6] - 6'd1;
    if (m_b > MAKE_LAST) m_b = MAKE_LAST;

    idx_ma = (cur_color ? BLACK_MAKE_BASE : WHITE_MAKE_BASE) + {2'd0, m_a};
    idx_ta = (cur_color ? BLACK_TERM_BASE : WHITE_TERM_BASE) + {2'd0, cur_count[5:0]};
    idx_mb = (in_q.pixel ? BLACK_MAKE_BASE : WHITE_MAKE_BASE) + {2'd0, m_b};
    idx_tb = (in_q.pixel ? BLACK_TERM_BASE : WHITE_TERM_BASE) + {2'd0, cnt_b[5:0]};

    c_ma = rom_code(idx_ma);
    c_ta = rom_code(idx_ta);
    c_mb = rom_code(idx_mb);
    c_tb = rom_code(idx_tb);
  end

  // Byte phase: an EOL always ends on a byte boundary
  always_comb begin
    ph1 = page_start_q ? bit_phase_q : 3'd0;
    ph2 = ph1 + (make_a ? c_ma.len[2:0] : 3'd0) + (chg_a ? c_ta.len[2:0] : 3'd0);
    ph3 = ph2 + (make_b ? c_mb.len[2:0] : 3'd0) + c_tb.len[2:0];
    fill = EOL_PHASE - ph3;
    c_eol.bits = EOL_BITS;
    c_eol.len  = EOL_LEN + {2'd0, fill};
  end

  // Lay the codes out in order; RTC chunks past eight are dropped
  always_comb begin
    o1    = {3'd0, !page_start_q};
    o3    = o1 + {3'd0, make_a} + {3'd0, chg_a};
    n_pre = o3 + (end_line ? {3'd0, make_b} + 4'd2 : 4'd0);
    if (!in_q.end_of_page) begin
      rtc_kept = 3'd0;
    end else if (n_pre > 4'd4) begin
      rtc_kept = 3'(4'd8 - n_pre);
    end else begin
      rtc_kept = 3'd4;
    end
    n_new = n_pre + {1'b0, rtc_kept};

    cand[0] = '{bits: EOL_BITS, len: EOL_LEN + {2'd0, EOL_PHASE - bit_phase_q}};
    cand[1] = c_ma;
    cand[2] = c_ta;
    cand[3] = c_mb;
    cand[4] = c_tb;
    cand[5] = c_eol;
    cand_en[0] = !page_start_q;
    cand_en[1] = make_a;
    cand_en[2] = chg_a;
    cand_en[3] = make_b;
    cand_en[4] = end_line;
    cand_en[5] = end_line;
    cand_pos[0] = 4'd0;
    cand_pos[1] = o1;
    cand_pos[2] = o1 + {3'd0, make_a};
    cand_pos[3] = o3;
    cand_pos[4] = o3 + {3'd0, make_b};
    cand_pos[5] = o3 + {3'd0, make_b} + 4'd1;
    for (int i = 0; i < 4; i++) begin
      cand[6+i]     = '{bits: RTC_CHUNK[i], len: RTC_LEN};
      cand_en[6+i]  = in_q.end_of_page;
      cand_pos[6+i] = o3 + {3'd0, make_b} + 4'd2 + 4'(i);
    end

    for (int j = 0; j < MAX_CODES; j++) begin
      slot_d[j] = slot_q[j];
    end
    for (int k = 0; k < NUM_CAND; k++) begin
      if (cand_en[k] && (cand_pos[k] < 4'd8)) begin
        slot_d[cand_pos[k][2:0]] = cand[k];
      end
    end
  end

  // Next run state
  always_comb begin
    page_start_d = !in_q.end_of_page;
    if (end_line) begin
      run_color_d = 1'b0;
      run_count_d = 12'd0;
      line_pos_d  = 12'd0;
      bit_phase_d = 3'd0 - rtc_kept;
    end else begin
      run_color_d = in_q.pixel;
      run_count_d = cnt_b;
      line_pos_d  = pos_b;
      bit_phase_d = ph2;
    end
    if (load) begin
      rem_d = n_new;
    end else if (pop) begin
      rem_d = rem_q - 4'd1;
    end else begin
      rem_d = rem_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      in_vld_q     <= 1'b0;
      run_color_q  <= 1'b0;
      run_count_q  <= 12'd0;
      line_pos_q   <= 12'd0;
      bit_phase_q  <= 3'd0;
      page_start_q <= 1'b0;
      rem_q        <= 4'd0;
      rd_ptr_q     <= 3'd0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) line_width_q <= cfg_wdata_i;
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (load) begin
        in_vld_q <= 1'b0;
      end
      if (load) begin
        run_color_q  <= run_color_d;
        run_count_q  <= run_count_d;
        line_pos_q   <= line_pos_d;
        bit_phase_q  <= bit_phase_d;
        page_start_q <= page_start_d;
        rd_ptr_q     <= 3'd0;
      end else if (pop) begin
        rd_ptr_q <= rd_ptr_q + 3'd1;
      end
      rem_q <= rem_d;
      if (pop) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_data_i;
    if (load) begin
      for (int j = 0; j < MAX_CODES; j++) begin
        slot_q[j] <= slot_d[j];
      end
    end
    if (pop) begin
      out_q.code_bits   <= slot_q[rd_ptr_q].bits;
      out_q.code_length <= slot_q[rd_ptr_q].len;
      out_q.last        <= rem_q == 4'd1;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Buffer never holds more than eight codes
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 4'd8) else $error("code buffer overfilled");

  // Final buffered code goes out flagged last
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (rem_q == 4'd1)) |=> (out_valid_o && out_data_o.last))
    else $error("last code not flagged");

  // Page flag is the inverse of the end-of-page bit of the coded pixel
  a_page_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (page_start_q != $past(in_q.end_of_page)))
    else $error("page flag mismatch");

  // Input stalls only while a pixel waits in the input register
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && (rem_q != 4'd0)))
    else $error("spurious input stall");

  // Codes carry a nonzero length
  a_len_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.code_length != 5'd0))
    else $error("zero-length code");
`endif

endmodule
